[rtl/core/tdcrhm_pkg.sv]
// ----------------------------------------------------------------------------
// TDC rollover hit mapper package
// Shared constants, action codes and the result record of the hit mapper.
// ----------------------------------------------------------------------------
package tdcrhm_pkg;

  // Channel and time geometry.
  localparam int NUM_CHANNELS = 4;
  localparam int TIME_BITS    = 19;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Readout word layout.
  localparam int RAW_CH_W    = 7;
  localparam int CHAN_LSB    = 19;
  localparam int FILLER_LSB  = 27;
  localparam int WORD_W      = 32;

  // Field widths of a result.
  localparam int ACTION_W    = 3;
  localparam int CHANNEL_W   = 2;
  localparam int TIME_OUT_W  = 19;
  localparam int MASK_OUT_W  = 4;

  // Configuration port.
  localparam int APB_AW           = 3;
  localparam int APB_DW           = 32;
  localparam int REG_CHANNEL_BASE = 0;
  localparam logic [RAW_CH_W-1:0] CHANNEL_BASE_RST = 7'd32;

  // Result action codes.
  typedef enum logic [ACTION_W-1:0] {
    ACT_FILLER  = 3'd0,
    ACT_INVALID = 3'd1,
    ACT_IGNORED = 3'd2,
    ACT_HIT     = 3'd3,
    ACT_RESTART = 3'd4
  } action_e;

  // One result transaction.
  typedef struct packed {
    action_e                 action;
    logic [CHANNEL_W-1:0]    channel;
    logic [TIME_OUT_W-1:0]   time_value;
    logic [MASK_OUT_W-1:0]   complete_mask;
    logic                    all_complete;
  } result_t;

endpackage

[rtl/core/tdcrhm_if.sv]
// ----------------------------------------------------------------------------
// TDC rollover hit mapper channel interfaces
// Valid/ready channels for readout words and for mapper results.
// ----------------------------------------------------------------------------
interface tdcrhm_in_if;
  import tdcrhm_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [WORD_W-1:0] raw_word;

  modport source (output valid, output command, output raw_word, input ready);
  modport sink   (input valid, input command, input raw_word, output ready);
endinterface

interface tdcrhm_out_if;
  import tdcrhm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [CHANNEL_W-1:0]  channel;
  logic [TIME_OUT_W-1:0] time_value;
  logic [MASK_OUT_W-1:0] complete_mask;
  logic                  all_complete;

  modport source (output valid, output action, output channel, output time_value,
                  output complete_mask, output all_complete, input ready);
  modport sink   (input valid, input action, input channel, input time_value,
                  input complete_mask, input all_complete, output ready);
endinterface

[rtl/core/tdcrhm_cfg.sv]
// ----------------------------------------------------------------------------
// TDC rollover hit mapper register file
// APB-style write/read access to the channel base register.
// ----------------------------------------------------------------------------
module tdcrhm_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tdcrhm_pkg::APB_AW-1:0]  paddr,
  input  logic [tdcrhm_pkg::APB_DW-1:0]  pwdata,
  output logic [tdcrhm_pkg::APB_DW-1:0]  prdata,
  output logic                           pready,
  output logic [tdcrhm_pkg::RAW_CH_W-1:0] channel_base_o
);
  import tdcrhm_pkg::*;

  logic [RAW_CH_W-1:0] channel_base_q, channel_base_d;
  logic                sel_base;

  // Register index is the word address.
  assign sel_base = (paddr[APB_AW-1:2] == 1'(REG_CHANNEL_BASE));
  assign pready   = 1'b1;

  // Write on the access phase.
  always_comb begin
    channel_base_d = channel_base_q;
    if (psel && penable && pwrite && sel_base) begin
      channel_base_d = pwdata[RAW_CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_base_q <= CHANNEL_BASE_RST;
    end else begin
      channel_base_q <= channel_base_d;
    end
  end

  // Read data is zero outside the register.
  assign prdata = sel_base ? {{(APB_DW-RAW_CH_W){1'b0}}, channel_base_q} : '0;

  assign channel_base_o = channel_base_q;

endmodule

[rtl/core/tdcrhm_core.sv]
// ----------------------------------------------------------------------------
// TDC rollover hit mapper core
// Per-channel rollover tracking and a registered result stage.
// ----------------------------------------------------------------------------
module tdcrhm_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [tdcrhm_pkg::RAW_CH_W-1:0] channel_base_i,
  tdcrhm_in_if.sink                       in_i,
  tdcrhm_out_if.source                    out_o
);
  import tdcrhm_pkg::*;

  logic [NUM_CHANNELS-1:0][TIME_BITS-1:0] prev_time_q, prev_time_d;
  logic [NUM_CHANNELS-1:0]                prev_valid_q, prev_valid_d;
  logic [NUM_CHANNELS-1:0]                ready_q, ready_d;
  logic [NUM_CHANNELS-1:0]                done_q, done_d;
  result_t                                res_q, res_d;
  logic                                   out_valid_q;

  logic                 in_accept;
  logic                 filler;
  logic [RAW_CH_W-1:0]  raw_ch;
  logic [RAW_CH_W-1:0]  idx_full;
  logic [CH_W-1:0]      idx;
  logic [TIME_BITS-1:0] word_time;
  logic                 rollover;

  // The result register frees up when it is empty or being taken.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  // Word decode.
  assign filler    = |in_i.raw_word[WORD_W-1:FILLER_LSB];
  assign raw_ch    = in_i.raw_word[CHAN_LSB+RAW_CH_W-1:CHAN_LSB];
  assign idx_full  = raw_ch - channel_base_i;
  assign idx       = idx_full[CH_W-1:0];
  assign word_time = in_i.raw_word[TIME_BITS-1:0];
  assign rollover  = prev_time_q[idx] > word_time;

  // Channel state update and result for one transaction.
  always_comb begin
    prev_time_d  = prev_time_q;
    prev_valid_d = prev_valid_q;
    ready_d      = ready_q;
    done_d       = done_q;
    res_d        = res_q;
    if (in_accept) begin
      res_d.action     = ACT_IGNORED;
      res_d.channel    = '0;
      res_d.time_value = '0;
      if (in_i.command) begin
        prev_valid_d     = '0;
        ready_d          = '0;
        done_d           = '0;
        res_d.action     = ACT_RESTART;
      end else if (filler) begin
        res_d.action     = ACT_FILLER;
      end else begin
        res_d.time_value = TIME_OUT_W'(word_time);
        if (idx_full >= RAW_CH_W'(NUM_CHANNELS)) begin
          res_d.action  = ACT_INVALID;
        end else begin
          res_d.channel = CHANNEL_W'(idx);
          if (done_q[idx]) begin
            // Complete channel: nothing more to record.
          end else if (!prev_valid_q[idx]) begin
            prev_valid_d[idx] = 1'b1;
            prev_time_d[idx]  = word_time;
          end else if (rollover && ready_q[idx]) begin
            done_d[idx] = 1'b1;
          end else if (rollover || ready_q[idx]) begin
            ready_d[idx]     = 1'b1;
            prev_time_d[idx] = word_time;
            res_d.action     = ACT_HIT;
          end
        end
      end
      res_d.complete_mask = MASK_OUT_W'(done_d);
      res_d.all_complete  = &done_d;
    end
  end

  // Channel state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q  <= '0;
      prev_valid_q <= '0;
      ready_q      <= '0;
      done_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      prev_time_q  <= prev_time_d;
      prev_valid_q <= prev_valid_d;
      ready_q      <= ready_d;
      done_q       <= done_d;
      if (in_i.ready) begin
        out_valid_q <= in_i.valid;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.action        = res_q.action;
  assign out_o.channel       = res_q.channel;
  assign out_o.time_value    = res_q.time_value;
  assign out_o.complete_mask = res_q.complete_mask;
  assign out_o.all_complete  = res_q.all_complete;

  // A channel completes only after it has become ready.
  a_done_needs_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q & ~ready_q) == '0)
    else $error("complete channel is not ready");

  // A channel becomes ready only after a recorded time.
  a_ready_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_q & ~prev_valid_q) == '0)
    else $error("ready channel has no recorded time");

  // A restart leaves every channel mark cleared.
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_i.command |=> prev_valid_q == '0 && ready_q == '0 && done_q == '0)
    else $error("restart did not clear channel marks");

  // A hit result always names a channel that is ready and not complete.
  a_hit_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !in_i.command && (res_d.action == ACT_HIT)
    |=> ready_q[$past(idx)] && !done_q[$past(idx)])
    else $error("hit marked on a channel that is not ready");

endmodule

[rtl/core/tdc_rollover_hit_mapper_top.sv]
// ----------------------------------------------------------------------------
// TDC rollover hit mapper top level
// Maps TDC readout words to hit marks per channel with rollover tracking.
// ----------------------------------------------------------------------------
//  Port     Direction  Role
//  in_i     sink       readout word or restart command per transaction
//  out_o    source     one result per input transaction
//  p*       APB        channel_base register at byte address 0
//
//  Each accepted transaction is written into the single result register,
//  which sets the latency; a new one is taken every cycle unless held off.
//  The input is held off only while a result waits and out_o.ready is low.
//  Reset clears all channel marks and sets channel_base to 32; no clearing
//  pass is needed.
// ----------------------------------------------------------------------------
module tdc_rollover_hit_mapper_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tdcrhm_in_if.sink                      in_i,
  tdcrhm_out_if.source                   out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tdcrhm_pkg::APB_AW-1:0]  paddr,
  input  logic [tdcrhm_pkg::APB_DW-1:0]  pwdata,
  output logic [tdcrhm_pkg::APB_DW-1:0]  prdata,
  output logic                           pready
);
  import tdcrhm_pkg::*;

  logic [RAW_CH_W-1:0] channel_base;

  // Register file.
  tdcrhm_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .channel_base_o (channel_base)
  );

  // Mapping datapath.
  tdcrhm_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .channel_base_i (channel_base),
    .in_i           (in_i),
    .out_o          (out_o)
  );

endmodule
